/* rtl/core/ksp_pkg.sv */
// shared types, constants and helpers for the knob smoothing and pickup block
// no dependencies
package ksp_pkg;

  // configuration of the block
  localparam int KNOB_COUNT    = 16;  // 1 .. 16
  localparam int HISTORY_DEPTH = 8;   // 2 .. 64
  localparam int DROP_BITS     = 2;   // 0 .. 6

  // field widths
  localparam int KNOB_W = 4;
  localparam int READ_W = 10;

  // derived sizes
  localparam int FULL_READ = 1023 >> DROP_BITS;
  localparam int KIDX_W    = (KNOB_COUNT > 1) ? $clog2(KNOB_COUNT) : 1;
  localparam int POS_W     = $clog2(HISTORY_DEPTH);
  localparam int RING_AW   = KIDX_W + POS_W;
  localparam int RING_DEPTH = KNOB_COUNT << POS_W;
  localparam int SUM_W     = $clog2(HISTORY_DEPTH * FULL_READ + 1);

  // averaging by the history depth: a shift, or a multiply by a reciprocal
  localparam bit HIST_POW2 = (HISTORY_DEPTH & (HISTORY_DEPTH - 1)) == 0;
  localparam int DIV_S     = SUM_W + POS_W;
  localparam int RECIP_W   = SUM_W + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_S) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_SET     = 2'd1,
    OP_RELEASE = 2'd2
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [KNOB_W-1:0] knob;
    logic [READ_W-1:0] raw;
    logic [READ_W-1:0] nv;
  } item_t;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [READ_W-1:0] last;
    logic [READ_W-1:0] held;
  } knob_state_t;

  typedef struct packed {
    logic [KNOB_W-1:0] knob;
    logic [READ_W-1:0] value;
    logic [READ_W-1:0] rd;
    logic              active;
  } result_t;

  function automatic logic knob_in_range(logic [KNOB_W-1:0] k);
    return (5'(k) < 5'(KNOB_COUNT));
  endfunction

endpackage

/* rtl/core/ksp_sample_ring.sv */
// per-knob ring of raw samples with its write pointers and fill flags
// depends on ksp_pkg
module ksp_sample_ring
  import ksp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [KNOB_W-1:0] knob_i,
  input  logic [READ_W-1:0] sample_i,
  output logic [READ_W-1:0] old_o
);

  logic [POS_W-1:0]  pos_q [KNOB_COUNT];
  logic              full_q [KNOB_COUNT];
  logic [READ_W-1:0] mem [RING_DEPTH];
  logic [READ_W-1:0] rd_q;
  logic              rd_full_q;

  logic [KIDX_W-1:0]  kidx;
  logic [POS_W-1:0]   pos;
  logic [RING_AW-1:0] addr;
  logic               wrap;

  assign kidx = knob_i[KIDX_W-1:0];
  assign pos  = pos_q[kidx];
  assign addr = {kidx, pos};
  assign wrap = (pos == POS_W'(HISTORY_DEPTH - 1));

  // entries fill in pointer order, so the slot under the pointer holds data once wrapped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KNOB_COUNT; i++) begin
        pos_q[i]  <= '0;
        full_q[i] <= 1'b0;
      end
      rd_full_q <= 1'b0;
    end else if (wr_en_i) begin
      rd_full_q   <= full_q[kidx];
      pos_q[kidx] <= wrap ? '0 : pos + POS_W'(1);
      if (wrap) begin
        full_q[kidx] <= 1'b1;
      end
    end
  end

  // read before write: the oldest sample comes out as the new one goes in
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      rd_q      <= mem[addr];
      mem[addr] <= sample_i;
    end
  end

  assign old_o = rd_full_q ? rd_q : '0;

endmodule

/* rtl/core/ksp_knob_store.sv */
// per-knob state memory (running sum, last read, held value) with write bypass
// depends on ksp_pkg
module ksp_knob_store
  import ksp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [KNOB_W-1:0] rd_knob_i,
  input  logic              wr_en_i,
  input  logic [KNOB_W-1:0] wr_knob_i,
  input  knob_state_t       wr_data_i,
  output knob_state_t       rd_data_o
);

  knob_state_t mem [KNOB_COUNT];
  knob_state_t rd_q;
  knob_state_t byp_data_q;
  logic        vld_q [KNOB_COUNT];
  logic        rd_vld_q;
  logic        byp_q;

  logic [KIDX_W-1:0] ra;
  logic [KIDX_W-1:0] wa;

  assign ra = rd_knob_i[KIDX_W-1:0];
  assign wa = wr_knob_i[KIDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KNOB_COUNT; i++) begin
        vld_q[i] <= 1'b0;
      end
      rd_vld_q <= 1'b0;
      byp_q    <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_vld_q <= vld_q[ra];
        byp_q    <= wr_en_i && (wa == ra);
      end
      if (wr_en_i) begin
        vld_q[wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q       <= mem[ra];
      byp_data_q <= wr_data_i;
    end
    if (wr_en_i) begin
      mem[wa] <= wr_data_i;
    end
  end

  // a write in the read cycle wins; a never written entry reads as zero
  assign rd_data_o = byp_q ? byp_data_q : (rd_vld_q ? rd_q : '0);

endmodule

/* rtl/core/ksp_update.sv */
// averaging, hysteresis and pickup rule for one item, plus the result fields
// depends on ksp_pkg
module ksp_update
  import ksp_pkg::*;
(
  input  item_t             item_i,
  input  knob_state_t       state_i,
  input  logic [READ_W-1:0] old_sample_i,
  input  logic              picked_i,
  output logic              we_o,
  output knob_state_t       state_o,
  output logic              pick_set_o,
  output result_t           result_o
);

  logic              ok;
  logic [SUM_W-1:0]  sum_n;
  logic [PROD_W-1:0] prod;
  logic [READ_W-1:0] avg;
  logic [READ_W-1:0] rd;
  logic [READ_W:0]   avg_p1;
  logic [READ_W:0]   prev_p1;
  logic              near;
  logic              pick_now;

  always_comb begin
    ok    = knob_in_range(item_i.knob);
    sum_n = state_i.sum - SUM_W'(old_sample_i >> DROP_BITS) + SUM_W'(item_i.raw >> DROP_BITS);
    prod  = PROD_W'(sum_n) * PROD_W'(RECIP);
    if (HIST_POW2) begin
      avg = READ_W'(sum_n >> POS_W);
    end else begin
      avg = READ_W'(prod >> DIV_S);
    end

    // one-step hysteresis, released at both ends of the scale
    avg_p1  = {1'b0, avg} + (READ_W + 1)'(1);
    prev_p1 = {1'b0, state_i.last} + (READ_W + 1)'(1);
    near    = (state_i.last == avg) || ({1'b0, state_i.last} == avg_p1) ||
              ({1'b0, avg} == prev_p1);
    if (near && (avg != '0) && (avg != READ_W'(FULL_READ))) begin
      rd = state_i.last;
    end else begin
      rd = avg;
    end

    // soft takeover: pick up on meeting from below or crossing either way
    pick_now = picked_i || ((state_i.last <= state_i.held) == (rd >= state_i.held));

    we_o       = 1'b0;
    state_o    = state_i;
    pick_set_o = 1'b0;
    case (item_i.op)
      OP_SAMPLE: begin
        if (ok) begin
          we_o         = 1'b1;
          state_o.sum  = sum_n;
          state_o.last = rd;
          pick_set_o   = pick_now;
          if (pick_now) begin
            state_o.held = rd;
          end
        end
      end
      OP_SET: begin
        if (ok) begin
          we_o         = 1'b1;
          state_o.held = item_i.nv;
        end
      end
      default: begin
      end
    endcase

    result_o.knob = item_i.knob;
    if (ok) begin
      result_o.value  = state_o.held;
      result_o.rd     = state_o.last;
      result_o.active = (item_i.op != OP_RELEASE) && (picked_i || pick_set_o);
    end else begin
      result_o.value  = '0;
      result_o.rd     = '0;
      result_o.active = 1'b0;
    end
  end

endmodule

/* rtl/core/knob_smoothing_pickup.sv */
// top level of the knob smoothing and soft takeover block
// depends on ksp_pkg, ksp_sample_ring, ksp_knob_store, ksp_update
//
//  channel   dir  handshake                      tdata / tuser
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: knob_index, raw_sample, new_value
//                                                tuser: operation
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: out_knob, knob_value,
//                                                       filtered_read, knob_active
//
// one transfer in and one result out per cycle, sustained while the output is not stalled;
// a result passes the compute stage (with the knob store read) and then the output register
// the sample ring is written on the input transfer itself; the knob store is
// written back as an item leaves the compute stage and bypassed into the next read
// reset clears pointers, fill flags, valid bits and pickup flags at once: no
// clearing pass, the block takes input from the first cycle after reset
// a stalled output holds the compute stage, which in turn holds off the input
module knob_smoothing_pickup
  import ksp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // knob_index[3:0], raw_sample[13:4], new_value[23:14]
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // out_knob[3:0], knob_value[13:4],
                                      // filtered_read[23:14], knob_active[24], zero above
);

  item_t       in_item;
  logic        in_xfer;
  logic        s1_adv;

  // compute stage
  logic        s1_valid_q;
  item_t       s1_item_q;

  // output register
  logic        out_valid_q;
  result_t     out_q;

  // pickup flags live in flip-flops: release clears them all at once
  logic        picked_q [KNOB_COUNT];

  logic [READ_W-1:0] old_sample;
  knob_state_t       rd_state;
  knob_state_t       wr_state;
  logic              wr_en;
  logic              pick_set;
  logic              picked_cur;
  result_t           result;

  assign in_item.op   = op_e'(s_axis_tuser);
  assign in_item.knob = s_axis_tdata[3:0];
  assign in_item.raw  = s_axis_tdata[13:4];
  assign in_item.nv   = s_axis_tdata[23:14];

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // oldest sample of the ring leaves as the new one enters
  ksp_sample_ring u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (in_xfer && (in_item.op == OP_SAMPLE) && knob_in_range(in_item.knob)),
    .knob_i   (in_item.knob),
    .sample_i (in_item.raw),
    .old_o    (old_sample)
  );

  // read on the input transfer, written back when the item leaves the compute stage
  ksp_knob_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_xfer),
    .rd_knob_i (in_item.knob),
    .wr_en_i   (s1_adv && wr_en),
    .wr_knob_i (s1_item_q.knob),
    .wr_data_i (wr_state),
    .rd_data_o (rd_state)
  );

  assign picked_cur = knob_in_range(s1_item_q.knob) ? picked_q[s1_item_q.knob[KIDX_W-1:0]]
                                                    : 1'b0;

  ksp_update u_update (
    .item_i       (s1_item_q),
    .state_i      (rd_state),
    .old_sample_i (old_sample),
    .picked_i     (picked_cur),
    .we_o         (wr_en),
    .state_o      (wr_state),
    .pick_set_o   (pick_set),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < KNOB_COUNT; i++) begin
        picked_q[i] <= 1'b0;
      end
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        if (s1_item_q.op == OP_RELEASE) begin
          for (int i = 0; i < KNOB_COUNT; i++) begin
            picked_q[i] <= 1'b0;
          end
        end else if (pick_set) begin
          picked_q[s1_item_q.knob[KIDX_W-1:0]] <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= in_item;
    end
    if (s1_adv) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q.active, out_q.rd, out_q.value, out_q.knob};

endmodule
